FILE: design/c2s_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package c2s_pkg;

    // 3 for the spatial build, 2 for the planar build (z and polar angle unused)
    localparam int SPACE_DIMS = 3;

    localparam int IN_W      = 24;                  // coordinate width
    localparam int FRAC_W    = 16;                  // coordinate scale inside the CORDIC
    localparam int DW        = 44;                  // CORDIC x/y datapath width
    localparam int AW        = 26;                  // angle accumulator width
    localparam int TURN_W    = 24;                  // accumulator units: 2^TURN_W per turn
    localparam int OUT_ANG_W = 16;                  // output angle width
    localparam int STEPS     = 22;                  // micro-rotations per CORDIC
    localparam int SHW       = 5;                   // shift / bit index width
    localparam int SW        = 2 * IN_W;            // sum of squares width
    localparam int RW        = 24;                  // root width
    localparam int GAIN_W    = 17;
    localparam int ZGW       = IN_W + GAIN_W + 1;   // z times gain

    localparam logic [GAIN_W-1:0] GAIN_Q16 = GAIN_W'(107922);

    localparam int HALF_TURN_I    = 1 << (TURN_W - 1);
    localparam int QUARTER_TURN_I = 1 << (TURN_W - 2);
    localparam int RND_I          = 1 << (TURN_W - OUT_ANG_W - 1);

    localparam logic signed [AW-1:0] HALF_TURN    = AW'(HALF_TURN_I);
    localparam logic signed [AW-1:0] QUARTER_TURN = AW'(QUARTER_TURN_I);
    localparam logic [TURN_W:0]      ANG_RND      = (TURN_W + 1)'(RND_I);
    localparam logic [OUT_ANG_W-1:0] QUARTER_OUT  = OUT_ANG_W'(1 << (OUT_ANG_W - 2));

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [AW-1:0] ang;
    } vec_t;

    typedef struct packed {
        logic [SW-1:0] rem;
        logic [RW-1:0] root;
    } sqrt_t;

    // per-point data that rides along the pipeline
    typedef struct packed {
        logic signed [ZGW-1:0] zg;
        logic                  xy_zero;
        logic                  origin;
        logic [OUT_ANG_W-1:0]  az;
        logic [RW-1:0]         root;
    } side_t;

    // round(atan(2^-i) * 2^24 / (2 pi))
    function automatic logic signed [AW-1:0] atan_step(input logic [SHW-1:0] idx);
        logic signed [AW-1:0] a;
        unique case (idx)
            5'd0:    a = AW'(2097152);
            5'd1:    a = AW'(1238021);
            5'd2:    a = AW'(654136);
            5'd3:    a = AW'(332050);
            5'd4:    a = AW'(166669);
            5'd5:    a = AW'(83416);
            5'd6:    a = AW'(41718);
            5'd7:    a = AW'(20860);
            5'd8:    a = AW'(10430);
            5'd9:    a = AW'(5215);
            5'd10:   a = AW'(2608);
            5'd11:   a = AW'(1304);
            5'd12:   a = AW'(652);
            5'd13:   a = AW'(326);
            5'd14:   a = AW'(163);
            5'd15:   a = AW'(81);
            5'd16:   a = AW'(41);
            5'd17:   a = AW'(20);
            5'd18:   a = AW'(10);
            5'd19:   a = AW'(5);
            5'd20:   a = AW'(3);
            5'd21:   a = AW'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

FILE: design/c2s_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module c2s_cordic_cell (
    input  logic                        clk,
    input  logic                        en,
    input  logic [c2s_pkg::SHW-1:0]     shift,
    input  c2s_pkg::vec_t               din,
    output c2s_pkg::vec_t               dout
);

    c2s_pkg::vec_t                     dout_reg;
    c2s_pkg::vec_t                     dout_next;
    logic signed [c2s_pkg::DW-1:0]     dx;
    logic signed [c2s_pkg::DW-1:0]     dy;
    logic signed [c2s_pkg::AW-1:0]     step;

    assign step = c2s_pkg::atan_step(shift);

    always_comb
    begin
        dx = din.y >>> shift;
        dy = din.x >>> shift;
        if (din.y > 0)
        begin
            dout_next.x   = din.x + dx;
            dout_next.y   = din.y - dy;
            dout_next.ang = din.ang + step;
        end
        else
        begin
            dout_next.x   = din.x - dx;
            dout_next.y   = din.y + dy;
            dout_next.ang = din.ang - step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

`default_nettype wire

FILE: design/c2s_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module c2s_sqrt_cell (
    input  logic                        clk,
    input  logic                        en,
    input  logic [c2s_pkg::SHW-1:0]     bit_idx,
    input  c2s_pkg::sqrt_t              din,
    output c2s_pkg::sqrt_t              dout
);

    c2s_pkg::sqrt_t                    dout_reg;
    c2s_pkg::sqrt_t                    dout_next;
    logic [c2s_pkg::SW:0]              base;
    logic [c2s_pkg::SW:0]              trial;

    // (root + 2^k)^2 - root^2 = root * 2^(k+1) + 2^(2k)
    always_comb
    begin
        base  = (c2s_pkg::SW + 1)'(din.root) << (bit_idx + c2s_pkg::SHW'(1));
        trial = base + ((c2s_pkg::SW + 1)'(1) << {bit_idx, 1'b0});
        dout_next = din;
        if ({1'b0, din.rem} >= trial)
        begin
            dout_next.rem  = din.rem - trial[c2s_pkg::SW-1:0];
            dout_next.root = din.root | (c2s_pkg::RW'(1) << bit_idx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

`default_nettype wire

FILE: design/c2s_prep.sv
`timescale 1ns / 1ps
`default_nettype none

module c2s_prep (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [c2s_pkg::IN_W-1:0]     x_coord,
    input  logic signed [c2s_pkg::IN_W-1:0]     y_coord,
    input  logic signed [c2s_pkg::IN_W-1:0]     z_coord,
    output c2s_pkg::vec_t                       vec,
    output c2s_pkg::sqrt_t                      sq,
    output c2s_pkg::side_t                      side
);

    logic signed [2*c2s_pkg::IN_W-1:0]  xx;
    logic signed [2*c2s_pkg::IN_W-1:0]  yy;
    logic signed [2*c2s_pkg::IN_W-1:0]  zz;
    logic signed [c2s_pkg::DW-1:0]      cx0;
    logic signed [c2s_pkg::DW-1:0]      cy0;

    logic [c2s_pkg::SW-1:0]             xsq_reg, xsq_next;
    logic [c2s_pkg::SW-1:0]             ysq_reg, ysq_next;
    logic [c2s_pkg::SW-1:0]             zsq_reg, zsq_next;
    c2s_pkg::vec_t                      veca_reg, veca_next;
    c2s_pkg::side_t                     sidea_reg, sidea_next;

    c2s_pkg::vec_t                      vecb_reg;
    c2s_pkg::sqrt_t                     sqb_reg, sqb_next;
    c2s_pkg::side_t                     sideb_reg;

    assign xx = x_coord * x_coord;
    assign yy = y_coord * y_coord;
    assign zz = z_coord * z_coord;

    assign cx0 = c2s_pkg::DW'(signed'({x_coord, {c2s_pkg::FRAC_W{1'b0}}}));
    assign cy0 = c2s_pkg::DW'(signed'({y_coord, {c2s_pkg::FRAC_W{1'b0}}}));

    always_comb
    begin
        xsq_next = c2s_pkg::SW'($unsigned(xx));
        ysq_next = c2s_pkg::SW'($unsigned(yy));
        zsq_next = (c2s_pkg::SPACE_DIMS == 3) ? c2s_pkg::SW'($unsigned(zz)) : '0;

        // left half plane: turn by a half turn first
        if (x_coord < 0)
        begin
            veca_next.x   = -cx0;
            veca_next.y   = -cy0;
            veca_next.ang = c2s_pkg::HALF_TURN;
        end
        else
        begin
            veca_next.x   = cx0;
            veca_next.y   = cy0;
            veca_next.ang = '0;
        end

        sidea_next.zg      = z_coord * $signed({1'b0, c2s_pkg::GAIN_Q16});
        sidea_next.xy_zero = (x_coord == 0) && (y_coord == 0);
        sidea_next.origin  = (x_coord == 0) && (y_coord == 0) && (z_coord == 0);
        sidea_next.az      = '0;
        sidea_next.root    = '0;

        sqb_next.rem  = xsq_reg + ysq_reg + zsq_reg;
        sqb_next.root = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xsq_reg   <= xsq_next;
            ysq_reg   <= ysq_next;
            zsq_reg   <= zsq_next;
            veca_reg  <= veca_next;
            sidea_reg <= sidea_next;
            vecb_reg  <= veca_reg;
            sqb_reg   <= sqb_next;
            sideb_reg <= sidea_reg;
        end
    end

    assign vec  = vecb_reg;
    assign sq   = sqb_reg;
    assign side = sideb_reg;

endmodule

`default_nettype wire

FILE: design/cartesian_to_spherical_top.sv
// Cartesian to spherical converter, fully pipelined.
// Point channel (point_valid / point_ready) takes signed x_coord, y_coord,
// z_coord; result channel (result_valid / result_ready) returns radius,
// azimuth (65536 units per turn) and polar_angle (0..32768).
// Throughput: one transaction per cycle on both channels while no stall holds the chain.
// Stages from acceptance to result_valid when the output is free:
// squaring / setup registers, 22 azimuth CORDIC cells, a swap stage,
// 22 polar CORDIC cells, a clamp/round stage, 1 output register. The square
// root runs as 24 bit cells alongside the azimuth chain.
// The chain of cells is the latency; all cells advance together.
// Stall: a result waits in the output register; one more result parks in a
// skid register, and only then point_ready drops and the chain holds until
// result_ready frees the output.
// Reset clears all valid bits; no clearing pass, point_ready is high once they clear.
`timescale 1ns / 1ps
`default_nettype none

module cartesian_to_spherical_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    point_valid,
    output logic                                    point_ready,
    input  logic signed [c2s_pkg::IN_W-1:0]         x_coord,
    input  logic signed [c2s_pkg::IN_W-1:0]         y_coord,
    input  logic signed [c2s_pkg::IN_W-1:0]         z_coord,
    output logic                                    result_valid,
    input  logic                                    result_ready,
    output logic [c2s_pkg::RW-1:0]                  radius,
    output logic [c2s_pkg::OUT_ANG_W-1:0]           azimuth,
    output logic [c2s_pkg::OUT_ANG_W-1:0]           polar_angle
);

    localparam int STEPS  = c2s_pkg::STEPS;
    localparam int AZ0    = 2;                      // first azimuth cell stage
    localparam int PPRE   = AZ0 + STEPS;            // swap / azimuth rounding stage
    localparam int POL0   = PPRE + 1;               // first polar cell stage
    localparam int FIN    = POL0 + STEPS;           // clamp / round stage
    localparam int NST    = FIN + 1;
    localparam int ROOT_S = AZ0 + c2s_pkg::RW;      // stage that captures the root
    localparam int TW     = c2s_pkg::TURN_W;
    localparam int OW     = c2s_pkg::OUT_ANG_W;

    typedef struct packed {
        logic [c2s_pkg::RW-1:0] rad;
        logic [OW-1:0]          az;
        logic [OW-1:0]          pol;
    } res_t;

    logic                   en;
    logic [NST-1:0]         vld_reg;

    c2s_pkg::vec_t          vec_p;
    c2s_pkg::sqrt_t         sq_p;
    c2s_pkg::side_t         side_p;

    c2s_pkg::vec_t          az_vec  [0:STEPS];
    c2s_pkg::vec_t          pol_vec [0:STEPS];
    c2s_pkg::sqrt_t         sq_chain [0:c2s_pkg::RW];

    c2s_pkg::side_t         side_reg  [AZ0:FIN-1];
    c2s_pkg::side_t         side_next [AZ0:FIN-1];

    logic [TW:0]            az_sum;
    logic [OW-1:0]          az_rnd;
    logic signed [c2s_pkg::DW-1:0] zg_ext;
    c2s_pkg::vec_t          pvec_reg, pvec_next;

    logic signed [c2s_pkg::AW-1:0] pang;
    logic [TW-1:0]          pclamp;
    logic [TW:0]            pol_sum;
    res_t                   fin_reg, fin_next;

    res_t                   out_reg, sk_reg;
    logic                   out_vld_reg, out_vld_next;
    logic                   sk_vld_reg, sk_vld_next;
    logic                   take, push, load_out, load_sk, from_sk;

    // the chain advances unless the skid register is holding a result
    assign en          = !sk_vld_reg;
    assign point_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], point_valid};
        end
    end

    c2s_prep u_prep (
        .clk     (clk),
        .en      (en),
        .x_coord (x_coord),
        .y_coord (y_coord),
        .z_coord (z_coord),
        .vec     (vec_p),
        .sq      (sq_p),
        .side    (side_p)
    );

    assign az_vec[0]   = vec_p;
    assign sq_chain[0] = sq_p;
    assign pol_vec[0]  = pvec_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_az
        c2s_cordic_cell u_cell (
            .clk   (clk),
            .en    (en),
            .shift (c2s_pkg::SHW'(i)),
            .din   (az_vec[i]),
            .dout  (az_vec[i+1])
        );
    end

    for (genvar j = 0; j < c2s_pkg::RW; j++)
    begin : g_sqrt
        c2s_sqrt_cell u_cell (
            .clk     (clk),
            .en      (en),
            .bit_idx (c2s_pkg::SHW'(c2s_pkg::RW - 1 - j)),
            .din     (sq_chain[j]),
            .dout    (sq_chain[j+1])
        );
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_pol
        c2s_cordic_cell u_cell (
            .clk   (clk),
            .en    (en),
            .shift (c2s_pkg::SHW'(i)),
            .din   (pol_vec[i]),
            .dout  (pol_vec[i+1])
        );
    end

    // azimuth rounding and polar CORDIC setup
    always_comb
    begin
        az_sum = {1'b0, az_vec[STEPS].ang[TW-1:0]} + c2s_pkg::ANG_RND;
        az_rnd = side_reg[PPRE-1].xy_zero ? c2s_pkg::QUARTER_OUT : az_sum[TW-1:TW-OW];
        zg_ext = c2s_pkg::DW'(side_reg[PPRE-1].zg);
        if (zg_ext < 0)
        begin
            pvec_next.x   = az_vec[STEPS].x;
            pvec_next.y   = -zg_ext;
            pvec_next.ang = c2s_pkg::QUARTER_TURN;
        end
        else
        begin
            pvec_next.x   = zg_ext;
            pvec_next.y   = az_vec[STEPS].x;
            pvec_next.ang = '0;
        end
    end

    always_comb
    begin
        side_next[AZ0] = side_p;
        for (int s = AZ0 + 1; s < FIN; s++)
        begin
            side_next[s] = side_reg[s-1];
        end
        side_next[PPRE].az     = az_rnd;
        side_next[ROOT_S].root = sq_chain[c2s_pkg::RW].root;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
            pvec_reg <= pvec_next;
            fin_reg  <= fin_next;
        end
    end

    // polar angle clamp to [0, half turn] and rounding
    always_comb
    begin
        pang = pol_vec[STEPS].ang;
        if (pang < 0)
        begin
            pclamp = '0;
        end
        else if (pang > c2s_pkg::HALF_TURN)
        begin
            pclamp = TW'(c2s_pkg::HALF_TURN);
        end
        else
        begin
            pclamp = pang[TW-1:0];
        end
        pol_sum = {1'b0, pclamp} + c2s_pkg::ANG_RND;

        fin_next.rad = side_reg[FIN-1].root;
        fin_next.az  = side_reg[FIN-1].az;
        if (c2s_pkg::SPACE_DIMS != 3)
        begin
            fin_next.pol = '0;
        end
        else if (side_reg[FIN-1].origin)
        begin
            fin_next.pol = c2s_pkg::QUARTER_OUT;
        end
        else
        begin
            fin_next.pol = pol_sum[TW-1:TW-OW];
        end
    end

    // output register with skid
    always_comb
    begin
        take         = out_vld_reg && result_ready;
        push         = en && vld_reg[FIN];
        out_vld_next = out_vld_reg;
        sk_vld_next  = sk_vld_reg;
        load_out     = 1'b0;
        load_sk      = 1'b0;
        from_sk      = 1'b0;
        if (sk_vld_reg)
        begin
            if (take)
            begin
                load_out    = 1'b1;
                from_sk     = 1'b1;
                sk_vld_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_vld_reg || take)
            begin
                load_out     = 1'b1;
                out_vld_next = 1'b1;
            end
            else
            begin
                load_sk     = 1'b1;
                sk_vld_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            sk_vld_reg  <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            sk_vld_reg  <= sk_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= from_sk ? sk_reg : fin_reg;
        end
        if (load_sk)
        begin
            sk_reg <= fin_reg;
        end
    end

    assign result_valid = out_vld_reg;
    assign radius       = out_reg.rad;
    assign azimuth      = out_reg.az;
    assign polar_angle  = out_reg.pol;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int  COORD_W       = c2s_pkg::IN_W;
    localparam int  RAD_W         = c2s_pkg::RW;
    localparam int  ANG_W         = c2s_pkg::OUT_ANG_W;
    localparam bit  THREE_D       = (c2s_pkg::SPACE_DIMS == 3);
    localparam int  CORDIC_ITERS  = 22;
    localparam longint GAIN_FIX   = 107922;         // CORDIC gain, Q16
    localparam longint HALF_ACC   = 64'd8388608;    // accumulator counts 2^-24 turn
    localparam longint QUART_ACC  = 64'd4194304;
    localparam logic [ANG_W-1:0] QUARTER_ANGLE = ANG_W'(16384);
    localparam int  RANDOM_POINTS = 1150;
    localparam int  SETTLE_CYCLES = 60;             // longer than the pipeline
    localparam int  CYCLE_LIMIT   = 600000;
    localparam int  MAX_REPORTS   = 10;

    localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] C_MIN = 24'sh800000;

    typedef struct packed {
        logic [RAD_W-1:0] radius;
        logic [ANG_W-1:0] azimuth;
        logic [ANG_W-1:0] polar_angle;
    } spherical_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic point_valid = 1'b0;
    logic point_ready;
    logic signed [COORD_W-1:0] x_coord = '0;
    logic signed [COORD_W-1:0] y_coord = '0;
    logic signed [COORD_W-1:0] z_coord = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    logic [RAD_W-1:0] radius;
    logic [ANG_W-1:0] azimuth;
    logic [ANG_W-1:0] polar_angle;

    spherical_t expected_points[$];
    int points_sent = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int stray_results = 0;
    int cycle_count = 0;
    bit source_gaps = 1'b0;
    bit sink_stalls = 1'b0;
    int stall_left = 0;

    cartesian_to_spherical_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .z_coord      (z_coord),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .radius       (radius),
        .azimuth      (azimuth),
        .polar_angle  (polar_angle)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_points.size());
            $display("** cartesian_to_spherical_top: FAILED **");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic longint atan_turns(input int idx);
        longint a;
        case (idx)
            0:  a = 2097152;
            1:  a = 1238021;
            2:  a = 654136;
            3:  a = 332050;
            4:  a = 166669;
            5:  a = 83416;
            6:  a = 41718;
            7:  a = 20860;
            8:  a = 10430;
            9:  a = 5215;
            10: a = 2608;
            11: a = 1304;
            12: a = 652;
            13: a = 326;
            14: a = 163;
            15: a = 81;
            16: a = 41;
            17: a = 20;
            18: a = 10;
            19: a = 5;
            20: a = 3;
            21: a = 1;
            default: a = 0;
        endcase
        return a;
    endfunction

    // vectoring mode: drives vy toward zero, returns the accumulated angle
    function automatic longint rotate_to_axis(inout longint vx, inout longint vy,
                                              input longint acc);
        longint dx;
        longint dy;
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0)
            begin
                vx += dx;
                vy -= dy;
                acc += atan_turns(i);
            end
            else
            begin
                vx -= dx;
                vy += dy;
                acc -= atan_turns(i);
            end
        end
        return acc;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > n)
            probe >>= 2;
        while (probe != 0)
        begin
            if (n >= root + probe)
            begin
                n -= root + probe;
                root = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic spherical_t compute_spherical(input logic signed [COORD_W-1:0] px,
                                                     input logic signed [COORD_W-1:0] py,
                                                     input logic signed [COORD_W-1:0] pz);
        longint x;
        longint y;
        longint z;
        longint sum;
        longint vx;
        longint vy;
        longint acc;
        longint rho;
        spherical_t r;
        x = px;
        y = py;
        z = pz;
        rho = 0;
        sum = x * x + y * y;
        if (THREE_D)
            sum += z * z;
        r.radius = RAD_W'(floor_sqrt(sum));

        if (x == 0 && y == 0)
            r.azimuth = QUARTER_ANGLE;
        else
        begin
            vx = x * 65536;
            vy = y * 65536;
            acc = 0;
            if (vx < 0)
            begin
                vx = -vx;
                vy = -vy;
                acc = HALF_ACC;
            end
            acc = rotate_to_axis(vx, vy, acc);
            // wrap to one turn, round, wrap again (rounding up to a full turn gives 0)
            r.azimuth = ANG_W'(((acc & 64'hFFFFFF) + 128) >> 8);
            rho = vx;
        end

        r.polar_angle = '0;
        if (THREE_D)
        begin
            if (x == 0 && y == 0 && z == 0)
                r.polar_angle = QUARTER_ANGLE;
            else
            begin
                vx = z * GAIN_FIX;
                vy = rho;
                acc = 0;
                if (vx < 0)
                begin
                    vy = -vx;
                    vx = rho;
                    acc = QUART_ACC;
                end
                acc = rotate_to_axis(vx, vy, acc);
                if (acc < 0)
                    acc = 0;
                if (acc > HALF_ACC)
                    acc = HALF_ACC;
                r.polar_angle = ANG_W'((acc + 128) >> 8);
            end
        end
        return r;
    endfunction

    // ---------------- idling ----------------

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 80)
            return $urandom_range(3, 1);
        else if (pick < 95)
            return $urandom_range(12, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    // result side: stalls come and go on their own, result_ready is driven at the rising edge
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready <= 1'b1;
                if (sink_stalls && $urandom_range(99) < 20)
                    stall_left = gap_length();
            end
        end
    end

    // ---------------- checking ----------------

    // valid and ready are stable in the second half of the cycle, so a transaction
    // seen here completes at the next rising edge
    always @(negedge clk)
    begin
        spherical_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_points.size() == 0)
            begin
                stray_results++;
                $display("unexpected result: radius=%0d azimuth=%0d polar=%0d",
                         radius, azimuth, polar_angle);
            end
            else
            begin
                want = expected_points.pop_front();
                results_checked++;
                if (want.radius !== radius || want.azimuth !== azimuth
                    || want.polar_angle !== polar_angle)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch #%0d: exp %0d/%0d/%0d, got %0d/%0d/%0d",
                                 results_checked, want.radius, want.azimuth,
                                 want.polar_angle, radius, azimuth, polar_angle);
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    // called at a rising edge; returns at the rising edge that takes the point, or after an idle gap that follows it
    task automatic send_point(input logic signed [COORD_W-1:0] px,
                              input logic signed [COORD_W-1:0] py,
                              input logic signed [COORD_W-1:0] pz);
        logic taken;
        point_valid <= 1'b1;
        x_coord <= px;
        y_coord <= py;
        z_coord <= pz;
        do
        begin
            @(negedge clk);
            taken = point_ready;
            @(posedge clk);
        end
        while (!taken);
        expected_points.push_back(compute_spherical(px, py, pz));
        points_sent++;
        if (source_gaps && $urandom_range(99) < 25)
        begin
            point_valid <= 1'b0;
            repeat (gap_length()) @(posedge clk);
        end
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord();
        logic signed [COORD_W-1:0] v;
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            v = COORD_W'($urandom);
        else if (pick < 60)
            v = COORD_W'($urandom_range(512)) - 24'sd256;
        else if (pick < 75)
        begin
            case ($urandom_range(4))
                0:       v = C_MAX;
                1:       v = C_MIN;
                2:       v = 24'sd1;
                3:       v = -24'sd1;
                default: v = '0;
            endcase
        end
        else
            v = $signed(COORD_W'($urandom)) >>> $urandom_range(22, 1);
        return v;
    endfunction

    task automatic test_field_extremes();
        send_point(C_MAX, C_MAX, C_MAX);
        send_point(C_MIN, C_MIN, C_MIN);
        send_point(C_MIN, C_MAX, C_MIN);
        send_point(C_MAX, C_MIN, C_MAX);
        send_point(C_MAX, 24'sd0, 24'sd0);
        send_point(C_MIN, 24'sd0, 24'sd0);
        send_point(24'sd0, C_MAX, 24'sd0);
        send_point(24'sd0, C_MIN, 24'sd0);
        send_point(24'sd1, 24'sd1, 24'sd1);
        send_point(-24'sd1, -24'sd1, -24'sd1);
        send_point(24'sd1, 24'sd0, 24'sd0);
        send_point(-24'sd1, 24'sd0, 24'sd0);
    endtask

    task automatic test_special_points();
        send_point(24'sd0, 24'sd0, 24'sd0);      // origin
        send_point(24'sd0, 24'sd0, C_MAX);       // on the z axis, both signs
        send_point(24'sd0, 24'sd0, C_MIN);
        send_point(24'sd0, 24'sd0, 24'sd1);
        send_point(24'sd0, 24'sd0, -24'sd1);
        send_point(C_MAX, -24'sd1, 24'sd0);      // azimuth rounds up to a full turn
        send_point(C_MIN, -24'sd1, 24'sd0);      // just past the half turn
        send_point(C_MIN, 24'sd1, C_MAX);
        send_point(24'sd5, -24'sd5, 24'sd0);     // z = 0: polar quarter turn
        send_point(24'sd0, 24'sd1, -24'sd1);
    endtask

    task automatic test_random_points(input int count);
        int until_switch;
        until_switch = 0;
        for (int n = 0; n < count; n++)
        begin
            // stretches with different idling on each side, some with none
            if (until_switch == 0)
            begin
                until_switch = $urandom_range(200, 60);
                source_gaps = ($urandom_range(1) == 1);
                sink_stalls = ($urandom_range(1) == 1);
            end
            until_switch--;
            send_point(rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    initial
    begin
        int directed;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        test_special_points();
        directed = points_sent;
        test_random_points(RANDOM_POINTS);

        point_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d points converted (%0d directed, %0d random), %0d results checked",
                 points_sent, directed, points_sent - directed, results_checked);
        $display("%0d mismatches, %0d unexpected results, %0d still pending, %0d cycles",
                 mismatch_count, stray_results, expected_points.size(), cycle_count);
        if (mismatch_count == 0 && stray_results == 0 && expected_points.size() == 0)
            $display("** cartesian_to_spherical_top: PASSED **");
        else
            $display("** cartesian_to_spherical_top: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
design/c2s_pkg.sv
design/c2s_cordic_cell.sv
design/c2s_sqrt_cell.sv
design/c2s_prep.sv
design/cartesian_to_spherical_top.sv
bench/testbench.sv
